FILE: sv/archive_symbol_map_parser_core_defines.svh
// ----------------------------------------------------------------------------
// archive_symbol_map_parser_core_defines.svh
// Assertion macros shared by the symbol map parser RTL.
// ----------------------------------------------------------------------------
`ifndef ARCHIVE_SYMBOL_MAP_PARSER_CORE_DEFINES_SVH
`define ARCHIVE_SYMBOL_MAP_PARSER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// Check that prop holds in the same cycle.
`define ASMP_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("symbol map parser assertion failed");
// Check that cond implies prop in the cycle after.
`define ASMP_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("symbol map parser assertion failed");
`else
`define ASMP_ASSERT(label, clk, rst_n, prop)
`define ASMP_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif

`endif

FILE: sv/asmp_pkg.sv
// ----------------------------------------------------------------------------
// asmp_pkg
// Types and constants of the archive symbol map parser.
// ----------------------------------------------------------------------------
package asmp_pkg;

    localparam int BYTE_W     = 8;
    localparam int WORD_W     = 64;
    localparam int STATUS_W   = 2;
    localparam int RES_BITS   = 4 * WORD_W + STATUS_W;
    localparam int TDATA_W    = ((RES_BITS + BYTE_W - 1) / BYTE_W) * BYTE_W;
    localparam int PAD_W      = TDATA_W - RES_BITS;

    typedef enum logic [1:0] {
        PH_COUNT,
        PH_OFFSETS,
        PH_TABLE
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_SHORT,
        ST_TABLE
    } status_t;

    localparam logic KIND_ENTRY  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              last_byte;
    } in_beat_t;

    typedef struct packed {
        logic                result_kind;
        logic [WORD_W-1:0]   entry_index;
        logic [WORD_W-1:0]   member_offset;
        logic [STATUS_W-1:0] parse_status;
        logic [WORD_W-1:0]   symbol_total;
        logic [WORD_W-1:0]   string_bytes;
    } result_t;

endpackage

FILE: sv/asmp_in_reg.sv
// ----------------------------------------------------------------------------
// asmp_in_reg
// Input register of the parser: holds one byte beat until the engine takes it.
// ----------------------------------------------------------------------------
module asmp_in_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  asmp_pkg::in_beat_t in_beat,
    input  logic              advance,
    output logic              step,
    output asmp_pkg::in_beat_t beat
);

    logic               valid_reg;
    asmp_pkg::in_beat_t beat_reg;

    assign in_ready = !valid_reg || advance;
    assign step     = valid_reg && advance;
    assign beat     = beat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            beat_reg <= in_beat;
        end
    end

endmodule

FILE: sv/asmp_engine.sv
// ----------------------------------------------------------------------------
// asmp_engine
// Parser state and per-byte update: count word, offsets, string table checks.
// ----------------------------------------------------------------------------
`include "archive_symbol_map_parser_core_defines.svh"

module asmp_engine (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  asmp_pkg::in_beat_t beat,
    output logic               res_valid,
    output asmp_pkg::result_t  res
);

    asmp_pkg::phase_t          phase_reg,   phase_next;
    asmp_pkg::status_t         err_reg,     err_next;
    logic [2:0]                bcnt_reg,    bcnt_next;
    logic [asmp_pkg::WORD_W-1:0] acc_reg,     acc_next;
    logic [asmp_pkg::WORD_W-1:0] count_reg,   count_next;
    logic [asmp_pkg::WORD_W-1:0] offsets_reg, offsets_next;
    logic [asmp_pkg::WORD_W-1:0] strings_reg, strings_next;
    logic [asmp_pkg::WORD_W-1:0] tlen_reg,    tlen_next;
    logic                      prev_nz_reg, prev_nz_next;

    logic [asmp_pkg::WORD_W-1:0] acc_shift;
    logic [asmp_pkg::WORD_W-1:0] offsets_inc;
    logic                      word_done;
    logic                      is_zero;
    logic                      have_entry;
    asmp_pkg::status_t         status;

    assign acc_shift   = {acc_reg[asmp_pkg::WORD_W-asmp_pkg::BYTE_W-1:0], beat.data_byte};
    assign word_done   = (bcnt_reg == 3'd7);
    assign offsets_inc = offsets_reg + 64'd1;
    assign is_zero     = (beat.data_byte == 8'd0);

    always_comb
    begin
        phase_next   = phase_reg;
        err_next     = err_reg;
        bcnt_next    = bcnt_reg;
        acc_next     = acc_reg;
        count_next   = count_reg;
        offsets_next = offsets_reg;
        strings_next = strings_reg;
        tlen_next    = tlen_reg;
        prev_nz_next = prev_nz_reg;
        have_entry   = 1'b0;
        status       = asmp_pkg::ST_OK;
        res          = '0;

        case (phase_reg)
            asmp_pkg::PH_COUNT:
            begin
                acc_next  = acc_shift;
                bcnt_next = bcnt_reg + 3'd1;
                if (word_done)
                begin
                    count_next = acc_shift;
                    acc_next   = '0;
                    phase_next = (acc_shift == 64'd0) ? asmp_pkg::PH_TABLE
                                                      : asmp_pkg::PH_OFFSETS;
                end
            end
            asmp_pkg::PH_OFFSETS:
            begin
                acc_next  = acc_shift;
                bcnt_next = bcnt_reg + 3'd1;
                if (word_done)
                begin
                    have_entry   = 1'b1;
                    acc_next     = '0;
                    offsets_next = offsets_inc;
                    if (offsets_inc == count_reg)
                    begin
                        phase_next = asmp_pkg::PH_TABLE;
                    end
                end
            end
            asmp_pkg::PH_TABLE:
            begin
                if (tlen_reg == 64'd0)
                begin
                    if (is_zero && count_reg != 64'd0 && err_reg == asmp_pkg::ST_OK)
                    begin
                        err_next = asmp_pkg::ST_TABLE;
                    end
                end
                else if (is_zero)
                begin
                    if (!prev_nz_reg)
                    begin
                        if (strings_reg < count_reg && err_reg == asmp_pkg::ST_OK)
                        begin
                            err_next = asmp_pkg::ST_TABLE;
                        end
                    end
                    else
                    begin
                        strings_next = strings_reg + 64'd1;
                    end
                end
                prev_nz_next = !is_zero;
                tlen_next    = tlen_reg + 64'd1;
            end
            default:
            begin
                phase_next = asmp_pkg::PH_COUNT;
            end
        endcase

        if (beat.last_byte)
        begin
            if (phase_next != asmp_pkg::PH_TABLE)
            begin
                status = asmp_pkg::ST_SHORT;
            end
            else if (err_next != asmp_pkg::ST_OK)
            begin
                status = err_next;
            end
            else if (tlen_next == 64'd0)
            begin
                status = (count_next != 64'd0) ? asmp_pkg::ST_TABLE : asmp_pkg::ST_OK;
            end
            else if (strings_next != count_next || !is_zero)
            begin
                status = asmp_pkg::ST_TABLE;
            end
            else
            begin
                status = asmp_pkg::ST_OK;
            end
            res.result_kind  = asmp_pkg::KIND_STATUS;
            res.parse_status = status;
            res.symbol_total = count_next;
            res.string_bytes = tlen_next;

            phase_next   = asmp_pkg::PH_COUNT;
            err_next     = asmp_pkg::ST_OK;
            bcnt_next    = '0;
            acc_next     = '0;
            count_next   = '0;
            offsets_next = '0;
            strings_next = '0;
            tlen_next    = '0;
            prev_nz_next = 1'b0;
        end
        else if (have_entry)
        begin
            res.result_kind   = asmp_pkg::KIND_ENTRY;
            res.entry_index   = offsets_reg;
            res.member_offset = acc_shift;
        end
    end

    assign res_valid = beat.last_byte || have_entry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= asmp_pkg::PH_COUNT;
            err_reg     <= asmp_pkg::ST_OK;
            bcnt_reg    <= '0;
            acc_reg     <= '0;
            count_reg   <= '0;
            offsets_reg <= '0;
            strings_reg <= '0;
            tlen_reg    <= '0;
            prev_nz_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            err_reg     <= err_next;
            bcnt_reg    <= bcnt_next;
            acc_reg     <= acc_next;
            count_reg   <= count_next;
            offsets_reg <= offsets_next;
            strings_reg <= strings_next;
            tlen_reg    <= tlen_next;
            prev_nz_reg <= prev_nz_next;
        end
    end

    `ASMP_ASSERT(a_entry_in_offsets, clk, rst_n, !(step && have_entry) || phase_reg == asmp_pkg::PH_OFFSETS)
    `ASMP_ASSERT(a_table_word_aligned, clk, rst_n, phase_reg != asmp_pkg::PH_TABLE || bcnt_reg == 3'd0)
    `ASMP_ASSERT(a_err_never_short, clk, rst_n, err_reg != asmp_pkg::ST_SHORT)
    `ASMP_ASSERT_NEXT(a_last_resets, clk, rst_n, step && beat.last_byte, phase_reg == asmp_pkg::PH_COUNT && tlen_reg == 64'd0 && count_reg == 64'd0)

endmodule

FILE: sv/asmp_out_reg.sv
// ----------------------------------------------------------------------------
// asmp_out_reg
// Result register of the parser: holds one result beat until it is taken.
// ----------------------------------------------------------------------------
module asmp_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic              res_valid,
    input  asmp_pkg::result_t res,
    output logic              advance,
    output logic              out_valid,
    input  logic              out_ready,
    output asmp_pkg::result_t out_res
);

    logic              valid_reg;
    asmp_pkg::result_t res_reg;

    assign advance   = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= step && res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && res_valid)
        begin
            res_reg <= res;
        end
    end

endmodule

FILE: sv/archive_symbol_map_parser_core.sv
// ----------------------------------------------------------------------------
// archive_symbol_map_parser_core
// Streaming parser for the symbol map member of a 64-bit SysV archive.
// ----------------------------------------------------------------------------
// Feed the member one byte per beat on s_axis, with s_axis_tlast on the final
// byte. The first eight bytes are the big-endian symbol count, then one
// big-endian 64-bit member offset per symbol, then the string table.
// Each completed offset leaves on m_axis as an entry beat (tuser 0) with its
// index; the final byte yields one status beat (tuser 1) with status, count
// and string table size, after which the parser is ready for the next member.
// A byte is taken into the input register, and its result is taken into the result
// register when the parser can advance, then shown on m_axis. The parser takes one
// byte per cycle while m_axis takes its results, with a combinational state update
// between the two registers.
// Bytes that finish no offset and are not last produce no beat.
// Reset clears all counters and flags and empties both registers.
// When m_axis_tready is low the result register holds, one more byte may sit
// in the input register, and s_axis_tready then drops until the result moves.
// ----------------------------------------------------------------------------
module archive_symbol_map_parser_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [asmp_pkg::BYTE_W-1:0]   s_axis_tdata,  // [7:0] data_byte
    input  logic                          s_axis_tlast,  // last_byte
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [63:0] entry_index, [127:64] member_offset, [129:128] parse_status,
    // [193:130] symbol_total, [257:194] string_bytes, [263:258] zero
    output logic [asmp_pkg::TDATA_W-1:0]  m_axis_tdata,
    output logic                          m_axis_tuser   // [0] result_kind
);

    asmp_pkg::in_beat_t in_beat;
    asmp_pkg::in_beat_t beat;
    asmp_pkg::result_t  res;
    asmp_pkg::result_t  out_res;
    logic               step;
    logic               advance;
    logic               res_valid;

    assign in_beat.data_byte = s_axis_tdata;
    assign in_beat.last_byte = s_axis_tlast;

    asmp_in_reg u_in_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_beat  (in_beat),
        .advance  (advance),
        .step     (step),
        .beat     (beat)
    );

    asmp_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .beat      (beat),
        .res_valid (res_valid),
        .res       (res)
    );

    asmp_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .res_valid (res_valid),
        .res       (res),
        .advance   (advance),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    assign m_axis_tdata = {{asmp_pkg::PAD_W{1'b0}},
                           out_res.string_bytes,
                           out_res.symbol_total,
                           out_res.parse_status,
                           out_res.member_offset,
                           out_res.entry_index};
    assign m_axis_tuser = out_res.result_kind;

endmodule

FILE: verif/archive_symbol_map_parser_checker.sv
// ----------------------------------------------------------------------------
// archive_symbol_map_parser_checker
// Watches both streams of the symbol map parser, tracks the member being
// parsed, and compares every result beat with the entry or status due next.
// ----------------------------------------------------------------------------
module archive_symbol_map_parser_checker
    import asmp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    input  logic               s_axis_tready,
    input  logic [BYTE_W-1:0]  s_axis_tdata,
    input  logic               s_axis_tlast,
    input  logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    input  logic [TDATA_W-1:0] m_axis_tdata,
    input  logic               m_axis_tuser,
    input  logic               run_done,
    output int unsigned        fail_count,
    output int                 open_results
);
    timeunit 1ns;
    timeprecision 1ps;

    phase_t            map_phase;
    logic [2:0]        word_pos;
    logic [WORD_W-1:0] word_acc;
    logic [WORD_W-1:0] sym_count;
    logic [WORD_W-1:0] offsets_done;
    logic [WORD_W-1:0] strings_seen;
    logic [WORD_W-1:0] table_len;
    logic              prev_nonzero;
    status_t           table_err;
    logic              done_seen;
    result_t           due_map_results[$];

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                   input logic [WORD_W-1:0] want);
        $display("%0t ns mismatch on %s: got 0x%0h, expected 0x%0h",
                 $realtime, what, got, want);
        fail_count++;
    endtask

    task automatic clear_map_state();
        map_phase    = PH_COUNT;
        word_pos     = '0;
        word_acc     = '0;
        sym_count    = '0;
        offsets_done = '0;
        strings_seen = '0;
        table_len    = '0;
        prev_nonzero = 1'b0;
        table_err    = ST_OK;
    endtask

    task automatic parse_map_byte(input logic [BYTE_W-1:0] b, input logic last);
        result_t r;
        logic    have_entry;
        status_t st;
        have_entry = 1'b0;
        r = '0;
        case (map_phase)
            PH_COUNT:
            begin
                word_acc = {word_acc[WORD_W-BYTE_W-1:0], b};
                word_pos = word_pos + 3'd1;
                if (word_pos == 3'd0)
                begin
                    sym_count = word_acc;
                    word_acc  = '0;
                    if (sym_count == 0)
                        map_phase = PH_TABLE;
                    else
                        map_phase = PH_OFFSETS;
                end
            end
            PH_OFFSETS:
            begin
                word_acc = {word_acc[WORD_W-BYTE_W-1:0], b};
                word_pos = word_pos + 3'd1;
                if (word_pos == 3'd0)
                begin
                    have_entry      = 1'b1;
                    r.entry_index   = offsets_done;
                    r.member_offset = word_acc;
                    word_acc        = '0;
                    offsets_done    = offsets_done + 1;
                    if (offsets_done == sym_count)
                        map_phase = PH_TABLE;
                end
            end
            default:
            begin
                if (table_len == 0)
                begin
                    if (b == 0 && sym_count != 0 && table_err == ST_OK)
                        table_err = ST_TABLE;
                end
                else if (b == 0)
                begin
                    if (!prev_nonzero)
                    begin
                        if (strings_seen < sym_count && table_err == ST_OK)
                            table_err = ST_TABLE;
                    end
                    else
                        strings_seen = strings_seen + 1;
                end
                prev_nonzero = (b != 0);
                table_len    = table_len + 1;
            end
        endcase

        if (last)
        begin
            if (map_phase != PH_TABLE)
                st = ST_SHORT;
            else if (table_err != ST_OK)
                st = table_err;
            else if (table_len == 0)
                st = (sym_count != 0) ? ST_TABLE : ST_OK;
            else if (strings_seen != sym_count || b != 0)
                st = ST_TABLE;
            else
                st = ST_OK;
            r = '0;
            r.result_kind  = KIND_STATUS;
            r.parse_status = st;
            r.symbol_total = sym_count;
            r.string_bytes = table_len;
            due_map_results.push_back(r);
            clear_map_state();
        end
        else if (have_entry)
        begin
            r.result_kind = KIND_ENTRY;
            due_map_results.push_back(r);
        end
    endtask

    task automatic check_map_result(input logic kind, input logic [TDATA_W-1:0] d);
        result_t want;
        if (due_map_results.size() == 0)
        begin
            report_mismatch("result beat with nothing due", WORD_W'(kind), '0);
            return;
        end
        want = due_map_results.pop_front();
        if (kind !== want.result_kind)
            report_mismatch("result_kind", WORD_W'(kind), WORD_W'(want.result_kind));
        if (d[63:0] !== want.entry_index)
            report_mismatch("entry_index", d[63:0], want.entry_index);
        if (d[127:64] !== want.member_offset)
            report_mismatch("member_offset", d[127:64], want.member_offset);
        if (d[129:128] !== want.parse_status)
            report_mismatch("parse_status", WORD_W'(d[129:128]), WORD_W'(want.parse_status));
        if (d[193:130] !== want.symbol_total)
            report_mismatch("symbol_total", d[193:130], want.symbol_total);
        if (d[257:194] !== want.string_bytes)
            report_mismatch("string_bytes", d[257:194], want.string_bytes);
        if (d[TDATA_W-1:RES_BITS] !== '0)
            report_mismatch("tdata padding", WORD_W'(d[TDATA_W-1:RES_BITS]), '0);
    endtask

    initial
    begin
        fail_count   = 0;
        open_results = 0;
        done_seen    = 1'b0;
        clear_map_state();
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_map_state();
            due_map_results.delete();
            open_results = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_map_result(m_axis_tuser, m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready)
                parse_map_byte(s_axis_tdata, s_axis_tlast);
            open_results = due_map_results.size();
            if (run_done && !done_seen)
            begin
                done_seen = 1'b1;
                if (due_map_results.size() != 0)
                    report_mismatch("results never delivered", WORD_W'(open_results), '0);
            end
        end
    end

endmodule

FILE: verif/archive_symbol_map_parser_core_test.sv
// ----------------------------------------------------------------------------
// archive_symbol_map_parser_core_test
// Feeds symbol map members byte by byte: a few fixed corner members, then
// random members, mostly well formed, some truncated or with a bad string
// table, some plain noise, under several idle and backpressure mixes.
// ----------------------------------------------------------------------------
module archive_symbol_map_parser_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import asmp_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [BYTE_W-1:0]  s_axis_tdata;
    logic               s_axis_tlast;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [TDATA_W-1:0] m_axis_tdata;
    logic               m_axis_tuser;
    logic               run_done;
    int unsigned        fail_count;
    int                 open_results;

    int                 send_idle;
    int                 recv_stall;
    bit                 hold_pending;
    int                 bytes_sent;
    logic [BYTE_W-1:0]  member_q[$];

    archive_symbol_map_parser_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    archive_symbol_map_parser_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .run_done      (run_done),
        .fail_count    (fail_count),
        .open_results  (open_results)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #200000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (400) @(negedge clk);
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall);
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
        while ($urandom_range(99) < send_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        @(negedge clk);
        bytes_sent++;
    endtask

    task automatic send_member();
        for (int i = 0; i < member_q.size(); i++)
            send_byte(member_q[i], i == member_q.size() - 1);
    endtask

    task automatic build_member(input int n_sym, input int n_str, input int empty_at,
                                input bit lead_zero, input bit drop_end);
        logic [WORD_W-1:0] count_word;
        int                fill;
        count_word = WORD_W'(n_sym);
        member_q.delete();
        for (int i = 7; i >= 0; i--)
            member_q.push_back(count_word[8*i +: 8]);
        for (int k = 0; k < n_sym; k++)
        begin
            fill = $urandom_range(9);
            for (int i = 0; i < 8; i++)
                member_q.push_back(fill == 0 ? 8'h00 :
                                   fill == 1 ? 8'hFF : 8'($urandom_range(255)));
        end
        if (lead_zero)
            member_q.push_back(8'h00);
        for (int k = 0; k < n_str; k++)
        begin
            if (k != empty_at)
                repeat ($urandom_range(1, 4)) member_q.push_back(8'($urandom_range(1, 255)));
            member_q.push_back(8'h00);
        end
        if (drop_end && member_q.size() > 8 + 8 * n_sym)
            void'(member_q.pop_back());
    endtask

    task automatic random_member();
        int n_sym;
        int pick;
        int cut;
        n_sym = ($urandom_range(9) == 0) ? $urandom_range(4, 7) : $urandom_range(0, 3);
        pick  = $urandom_range(15);
        if (pick < 10)
            build_member(n_sym, n_sym, -1, 1'b0, 1'b0);
        else if (pick == 10)
            build_member(n_sym, n_sym, -1, 1'b1, 1'b0);
        else if (pick == 11)
            build_member(n_sym, n_sym + 1, $urandom_range(0, n_sym), 1'b0, 1'b0);
        else if (pick == 12)
            build_member(n_sym, (n_sym > 0 && $urandom_range(1) == 1) ? n_sym - 1 : n_sym + 1,
                         -1, 1'b0, 1'b0);
        else if (pick == 13)
            build_member(n_sym, n_sym, -1, 1'b0, 1'b1);
        else if (pick == 14)
        begin
            build_member(n_sym, n_sym, -1, 1'b0, 1'b0);
            cut = $urandom_range(1, 8 + 8 * n_sym);
            while (member_q.size() > cut)
                void'(member_q.pop_back());
        end
        else
        begin
            member_q.delete();
            repeat ($urandom_range(1, 20)) member_q.push_back(8'($urandom_range(255)));
        end
        send_member();
    endtask

    initial
    begin
        int phase_start;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        rst_n         = 1'b0;
        run_done      = 1'b0;
        send_idle     = 0;
        recv_stall    = 0;
        hold_pending  = 1'b0;
        bytes_sent    = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // one-byte member, count never completes
        member_q = '{8'hA5};
        send_member();
        // zero count, no string table
        build_member(0, 0, -1, 1'b0, 1'b0);
        send_member();
        // all-ones count cut off right after the count word
        member_q = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_member();
        // zero count, table holds a single NUL
        build_member(0, 0, -1, 1'b1, 1'b0);
        send_member();

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 78; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 78; end
                default: begin send_idle = 35; recv_stall = 35; end
            endcase
            if (ph == 0)
            begin
                // hold the output long enough to back up the input
                hold_pending = 1'b1;
                build_member(7, 7, -1, 1'b0, 1'b0);
                send_member();
                s_axis_tvalid <= 1'b0;
                wait (open_results == 0);
                @(negedge clk);
            end
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < 60)
                random_member();
            s_axis_tvalid <= 1'b0;
            wait (open_results == 0);
            @(negedge clk);
        end

        repeat (6) @(negedge clk);
        run_done = 1'b1;
        @(negedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
